### rtl/core/cfm_pkg.sv
// Shared types and constants of the capture frequency meter.
package cfm_pkg;

  localparam int CHANNEL_BITS = 2;
  localparam int CAPTURE_BITS = 16;
  localparam int PERIOD_BITS  = 16;
  localparam int FREQ_BITS    = 40;
  localparam int CLOCK_BITS   = 32;

  localparam logic [CLOCK_BITS-1:0] DEFAULT_CLOCK_HZ = 32'd44_000_000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/core/cfm_cell.sv
// One bit cell of the dividend/quotient shift chain.
module cfm_cell (
  input  logic clk,
  input  logic load,
  input  logic load_bit,
  input  logic shift,
  input  logic shift_in,
  output logic q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_bit;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

### rtl/core/cfm_divider.sv
// Bit-serial restoring divider built on a chain of one-bit cells.
module cfm_divider #(
  parameter int DIVIDEND_BITS = 40,
  parameter int DIVISOR_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIVIDEND_BITS-1:0]  dividend,
  input  logic [DIVISOR_BITS-1:0]   divisor,
  output logic [DIVIDEND_BITS-1:0]  quotient,
  output cfm_pkg::div_status_t      status
);
  import cfm_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [CNT_W-1:0]        count;
  logic                    done;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] rem_next;
  logic [DIVISOR_BITS:0]   trial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    qbit;
  logic                    step;
  logic [DIVIDEND_BITS-1:0] chain;

  assign step = (count != '0);

  // remainder step: shift in the top cell, subtract when it fits
  always_comb begin
    trial = {rem, chain[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dsr};
    qbit  = (trial >= {1'b0, dsr});
    rem_next = qbit ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
  end

  for (genvar i = 0; i < DIVIDEND_BITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      cfm_cell u_cell (
        .clk      (clk),
        .load     (start),
        .load_bit (dividend[i]),
        .shift    (step),
        .shift_in (qbit),
        .q        (chain[i])
      );
    end else begin : g_rest
      cfm_cell u_cell (
        .clk      (clk),
        .load     (start),
        .load_bit (dividend[i]),
        .shift    (step),
        .shift_in (chain[i-1]),
        .q        (chain[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
    end else if (step) begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(DIVIDEND_BITS);
      done  <= 1'b0;
    end else begin
      done <= (count == CNT_W'(1));
      if (step) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign quotient    = chain;
  assign status.busy = step;
  assign status.done = done;

endmodule

### rtl/core/capture_frequency_meter.sv
// Top level of the capture frequency meter.
//
// Input stream s_*: s_tuser carries the capture channel, s_tdata the 16-bit
// capture value. Each item yields one result on m_*: m_tdata holds the tick
// period since the channel's previous capture and the frequency
// clock * 2^FRACTION_BITS / period (truncated, saturated to 40 bits);
// m_tuser flags a zero period, for which the frequency reads 0.
// The cfg_* channel writes the counter clock in hertz; zero means 44 MHz.
// It is always ready; it must be written only while the block is idle, which the block itself does not enforce.
// The result is computed by the bit-serial divider, stepping one quotient
// bit per cycle along its cell chain, and is then registered in the output
// register. One item is in work at a time; a new item is taken only after
// the result has been moved into the output register.
// A finished result waits in the output register while m_tready is low;
// the next item can be accepted and divided meanwhile, and its result
// waits in the divider until the output register frees.
// Reset clears every channel's stored capture to zero, the clock register
// to zero and drops m_tvalid.
module capture_frequency_meter #(
  parameter int CHANNEL_COUNT = 4,
  parameter int COUNTER_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cfm_pkg::CLOCK_BITS-1:0]     cfg_data,   // timer_clock_hz
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cfm_pkg::CAPTURE_BITS-1:0]   s_tdata,    // capture_value
  input  logic [cfm_pkg::CHANNEL_BITS-1:0]   s_tuser,    // channel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [55:0]                        m_tdata,    // period_ticks, frequency_q8
  output logic                               m_tuser     // zero_period
);
  import cfm_pkg::*;

  localparam int CH_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int DIV_BITS = CLOCK_BITS + FRACTION_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [CLOCK_BITS-1:0]   timer_clock_hz;
  logic [COUNTER_BITS-1:0] prev_capture [CHANNEL_COUNT];
  logic [CH_W-1:0]         ch_idx;
  logic [COUNTER_BITS-1:0] cur;
  logic [COUNTER_BITS-1:0] period;
  logic [CLOCK_BITS-1:0]   clock_hz;
  logic [DIV_BITS-1:0]     dividend;
  logic [DIV_BITS-1:0]     quotient;
  logic [FREQ_BITS-1:0]    freq_val;
  div_status_t             div_stat;
  logic [PERIOD_BITS-1:0]  pend_period;
  logic                    pend_zero;
  logic                    in_accept;
  logic                    out_free;
  logic                    load_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (CHANNEL_COUNT == 1) begin
      ch_idx = '0;
    end else if (32'(s_tuser) >= CHANNEL_COUNT) begin
      ch_idx = CH_W'(32'(s_tuser) - CHANNEL_COUNT);
    end else begin
      ch_idx = CH_W'(s_tuser);
    end
  end

  assign cur      = COUNTER_BITS'(s_tdata);
  assign period   = cur - prev_capture[ch_idx];
  assign clock_hz = (timer_clock_hz == '0) ? DEFAULT_CLOCK_HZ : timer_clock_hz;
  assign dividend = DIV_BITS'(clock_hz) << FRACTION_BITS;

  cfm_divider #(
    .DIVIDEND_BITS (DIV_BITS),
    .DIVISOR_BITS  (COUNTER_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .dividend (dividend),
    .divisor  (period),
    .quotient (quotient),
    .status   (div_stat)
  );

  if (DIV_BITS > FREQ_BITS) begin : g_sat
    assign freq_val = (|quotient[DIV_BITS-1:FREQ_BITS]) ? '1 : quotient[FREQ_BITS-1:0];
  end else begin : g_nosat
    assign freq_val = FREQ_BITS'(quotient);
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      timer_clock_hz <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        prev_capture[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        timer_clock_hz <= cfg_data;
      end
      if (in_accept) begin
        prev_capture[ch_idx] <= cur;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_period <= PERIOD_BITS'(period);
      pend_zero   <= (period == '0);
    end
    if (load_out) begin
      m_tdata <= {(pend_zero ? '0 : freq_val), pend_period};
      m_tuser <= pend_zero;
    end
  end

  // a taken item always starts a division
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_DIV) && div_stat.busy)
    else $error("accepted item did not start the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside a division");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("ready while the divider is busy");

  a_zero_freq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[55:16] == '0))
    else $error("zero period with non-zero frequency");

endmodule
